// ===== hdl/bal_pkg.sv =====
// Shared constants, operation codes and control structs of the bounded array list.
`timescale 1ns / 1ps
`default_nettype none
package bal_pkg;

  localparam int CAPACITY = 64;

  // fixed field widths of the item and result channels
  localparam int FUNC_W = 3;
  localparam int IDX_W  = 6;
  localparam int WORD_W = 32;
  localparam int LEN_W  = 7;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  // common width for comparing index, count and length values
  localparam int EXT_A  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int EXT_W  = (EXT_A > LEN_W) ? EXT_A : LEN_W;

  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd4;

  localparam logic signed [WORD_W-1:0] FAIL_WORD = -32'sd999999;

  typedef struct packed {
    logic load_item;
    logic set_ok;
    logic set_fail;
    logic take_rd;
    logic rd_index;
    logic wr_at_index;
    logic wr_at_count;
    logic ptr_init_dn;
    logic ptr_init_up;
    logic shift_dn;
    logic shift_up;
    logic cnt_inc;
    logic cnt_dec;
    logic out_load;
  } bal_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              valid;
    logic              full;
    logic              more_dn;
    logic              more_up;
    logic              out_free;
  } bal_sts_t;

endpackage
`default_nettype wire

// ===== hdl/bal_if.sv =====
// Valid/ready channel interfaces for operation items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface bal_in_if;
  logic                             valid;
  logic                             ready;
  logic [bal_pkg::FUNC_W-1:0]       func;
  logic [bal_pkg::IDX_W-1:0]        index;
  logic signed [bal_pkg::WORD_W-1:0] value;

  modport source (output valid, output func, output index, output value, input ready);
  modport sink   (input valid, input func, input index, input value, output ready);
endinterface

interface bal_out_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [bal_pkg::WORD_W-1:0] read_value;
  logic [bal_pkg::LEN_W-1:0]         length_now;

  modport source (output valid, output ok, output read_value, output length_now,
                  input ready);
  modport sink   (input valid, input ok, input read_value, input length_now,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/bal_datapath.sv =====
// Datapath: entry memory, count, shift pointer, item and result registers.
`timescale 1ns / 1ps
`default_nettype none
module bal_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bal_pkg::bal_cmd_t                 cmd,
  output bal_pkg::bal_sts_t                 sts,
  input  logic [bal_pkg::FUNC_W-1:0]        in_func,
  input  logic [bal_pkg::IDX_W-1:0]         in_index,
  input  logic signed [bal_pkg::WORD_W-1:0] in_value,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_ok,
  output logic signed [bal_pkg::WORD_W-1:0] out_read_value,
  output logic [bal_pkg::LEN_W-1:0]         out_length_now
);

  logic [bal_pkg::WORD_W-1:0] mem_r [bal_pkg::CAPACITY];

  logic [bal_pkg::FUNC_W-1:0] func_r;
  logic [bal_pkg::IDX_W-1:0]  index_r;
  logic [bal_pkg::WORD_W-1:0] value_r;
  logic [bal_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [bal_pkg::CNT_W-1:0]  ptr_r, ptr_nxt;
  logic                       mv_pend_r;
  logic [bal_pkg::ADDR_W-1:0] mv_waddr_r, mv_waddr_nxt;
  logic [bal_pkg::WORD_W-1:0] rd_data_r;
  logic                       ok_r;
  logic [bal_pkg::WORD_W-1:0] rv_r;
  logic                       out_valid_r;
  logic                       out_ok_r;
  logic [bal_pkg::WORD_W-1:0] out_rv_r;
  logic [bal_pkg::LEN_W-1:0]  out_len_r;

  logic [bal_pkg::EXT_W-1:0]  idx_ext, cnt_ext, ptr_ext, idx_p1;
  logic [bal_pkg::CNT_W-1:0]  ptr_m1;
  logic                       we, re;
  logic [bal_pkg::ADDR_W-1:0] waddr, raddr;
  logic [bal_pkg::WORD_W-1:0] wdata;

  assign idx_ext = bal_pkg::EXT_W'(index_r);
  assign cnt_ext = bal_pkg::EXT_W'(count_r);
  assign ptr_ext = bal_pkg::EXT_W'(ptr_r);
  assign idx_p1  = idx_ext + bal_pkg::EXT_W'(1);
  assign ptr_m1  = ptr_r - bal_pkg::CNT_W'(1);

  assign sts.func     = func_r;
  assign sts.valid    = idx_ext < cnt_ext;
  assign sts.full     = count_r >= bal_pkg::CNT_W'(bal_pkg::CAPACITY);
  assign sts.more_dn  = ptr_r < count_r;
  assign sts.more_up  = ptr_ext > idx_ext;
  assign sts.out_free = !out_valid_r || out_ready;

  // a moved word is written in the cycle after its read; that write wins the port
  always_comb begin
    we    = 1'b0;
    waddr = idx_ext[bal_pkg::ADDR_W-1:0];
    wdata = value_r;
    if (mv_pend_r) begin
      we    = 1'b1;
      waddr = mv_waddr_r;
      wdata = rd_data_r;
    end else if (cmd.wr_at_index) begin
      we    = 1'b1;
    end else if (cmd.wr_at_count) begin
      we    = 1'b1;
      waddr = count_r[bal_pkg::ADDR_W-1:0];
    end
  end

  always_comb begin
    re           = 1'b0;
    raddr        = idx_ext[bal_pkg::ADDR_W-1:0];
    mv_waddr_nxt = mv_waddr_r;
    ptr_nxt      = ptr_r;
    if (cmd.rd_index) begin
      re = 1'b1;
    end
    if (cmd.ptr_init_dn) begin
      ptr_nxt = idx_p1[bal_pkg::CNT_W-1:0];
    end else if (cmd.ptr_init_up) begin
      ptr_nxt = count_r;
    end else if (cmd.shift_dn) begin
      re           = 1'b1;
      raddr        = ptr_r[bal_pkg::ADDR_W-1:0];
      mv_waddr_nxt = ptr_m1[bal_pkg::ADDR_W-1:0];
      ptr_nxt      = ptr_r + bal_pkg::CNT_W'(1);
    end else if (cmd.shift_up) begin
      re           = 1'b1;
      raddr        = ptr_m1[bal_pkg::ADDR_W-1:0];
      mv_waddr_nxt = ptr_r[bal_pkg::ADDR_W-1:0];
      ptr_nxt      = ptr_m1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + bal_pkg::CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - bal_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      mv_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      mv_pend_r <= cmd.shift_dn || cmd.shift_up;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    mv_waddr_r <= mv_waddr_nxt;
    if (cmd.load_item) begin
      func_r  <= in_func;
      index_r <= in_index;
      value_r <= in_value;
      ok_r    <= 1'b0;
      rv_r    <= '0;
    end else begin
      if (cmd.set_ok) begin
        ok_r <= 1'b1;
      end
      if (cmd.set_fail) begin
        rv_r <= bal_pkg::FAIL_WORD;
      end else if (cmd.take_rd) begin
        rv_r <= rd_data_r;
      end
    end
    if (cmd.out_load) begin
      out_ok_r  <= ok_r;
      out_rv_r  <= rv_r;
      out_len_r <= cnt_ext[bal_pkg::LEN_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_rv_r;
  assign out_length_now = out_len_r;

endmodule
`default_nettype wire

// ===== hdl/bal_ctrl.sv =====
// Controller: sequences one operation at a time over the datapath.
`timescale 1ns / 1ps
`default_nettype none
module bal_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bal_pkg::bal_sts_t sts,
  output bal_pkg::bal_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       is_insert;

  assign is_insert = sts.func == bal_pkg::FN_INSERT;
  assign in_ready  = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (sts.func)
          bal_pkg::FN_APPEND: begin
            if (!sts.full) begin
              cmd.wr_at_count = 1'b1;
              cmd.cnt_inc     = 1'b1;
              cmd.set_ok      = 1'b1;
            end
          end
          bal_pkg::FN_READ: begin
            if (sts.valid) begin
              cmd.rd_index = 1'b1;
              cmd.set_ok   = 1'b1;
              state_nxt    = S_READ;
            end else begin
              cmd.set_fail = 1'b1;
            end
          end
          bal_pkg::FN_WRITE: begin
            if (sts.valid) begin
              cmd.wr_at_index = 1'b1;
              cmd.set_ok      = 1'b1;
            end
          end
          bal_pkg::FN_REMOVE: begin
            if (sts.valid) begin
              cmd.ptr_init_dn = 1'b1;
              cmd.set_ok      = 1'b1;
              state_nxt       = S_SHIFT;
            end
          end
          bal_pkg::FN_INSERT: begin
            if (sts.valid && !sts.full) begin
              cmd.ptr_init_up = 1'b1;
              cmd.set_ok      = 1'b1;
              state_nxt       = S_SHIFT;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT: begin
        // one entry read per cycle; its write follows in the next cycle
        if (is_insert) begin
          if (sts.more_up) begin
            cmd.shift_up = 1'b1;
          end else begin
            state_nxt = S_FLUSH;
          end
        end else begin
          if (sts.more_dn) begin
            cmd.shift_dn = 1'b1;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (is_insert) begin
          state_nxt = S_PUT;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_PUT: begin
        cmd.wr_at_index = 1'b1;
        cmd.cnt_inc     = 1'b1;
        state_nxt       = S_DONE;
      end
      S_READ: begin
        cmd.take_rd = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bounded_array_list_core.sv =====
// Top level of the bounded array list: controller plus datapath.
//
// The in_ch channel carries one operation item (func, index, value); the
// out_ch channel returns one result item (ok, read_value, length_now) for
// every accepted item, in order. Both are valid/ready: an item moves on a
// clock edge with valid and ready high.
// One item is worked on at a time; in_ch.ready is high only while the
// controller is idle. After the decode step, append, overwrite and failed
// ops go straight to the result; a read first takes the memory output; a
// remove shifts the entries above index i down, then drops the count; an
// insert shifts the entries from index i up, then writes the new value.
// The entry memory allows one read and one write per cycle: a shift moves
// one entry per cycle, read and write overlapped.
// The result sits in an output register; a stalled receiver holds it there
// and the block accepts and works on the next item meanwhile, waiting only
// to hand its own result over.
// Synchronous active-low reset empties the list and drops any pending
// result; entry contents are not cleared, as no entry past the count is
// ever read.
`timescale 1ns / 1ps
`default_nettype none
module bounded_array_list_core (
  input  logic       clk,
  input  logic       rst_n,
  bal_in_if.sink     in_ch,
  bal_out_if.source  out_ch
);

  bal_pkg::bal_cmd_t cmd;
  bal_pkg::bal_sts_t sts;
  logic              in_rdy;

  assign in_ch.ready = in_rdy;

  bal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  bal_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_ch.func),
    .in_index       (in_ch.index),
    .in_value       (in_ch.value),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ok         (out_ch.ok),
    .out_read_value (out_ch.read_value),
    .out_length_now (out_ch.length_now)
  );

  // only one item in flight
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_rdy) |=> !in_rdy)
    else $error("item accepted while another is at work");

  // a new result never overwrites one still waiting
  a_no_result_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register loaded while occupied");

  // appending and inserting grow the list only below capacity
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_at_count || cmd.cnt_inc) |-> !sts.full)
    else $error("list grows past capacity");

endmodule
`default_nettype wire
